### rtl/bayer_bilinear_demosaic_defines.svh
// assertion macros shared by the demosaic checker
`ifndef BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bbd_pkg.sv
// shared types and constants of the bilinear bayer demosaic
package bbd_pkg;

	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 13;
	localparam int ROW_BITS      = 13;
	localparam int TILE_BITS     = 2;

	localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TILE_PATTERN = 2'd2;

	localparam int MIN_DIM            = 3;
	localparam int MAX_HEIGHT         = 4096;
	localparam int IMAGE_WIDTH_RESET  = 640;
	localparam int IMAGE_HEIGHT_RESET = 480;

	typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

	typedef struct packed {
		logic shift;
		logic emit;
		logic interior;
		logic red_row;
		logic red_col;
		logic last;
	} stage_ctl_t;

endpackage

### rtl/bayer_bilinear_demosaic.sv
// bilinear bayer demosaic with two line memories and a 3x3 window
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tdata raw_pixel, s_tuser filler
// m_       out  m_tvalid/m_tready   m_tdata red,green,blue, m_tlast frame_end
// cfg_     in   cfg_valid/cfg_ready cfg_addr register index, cfg_data value
//
// one request per cycle sustained while the output does not stall; a result is
// registered in stage 1 with the line memory reads, then in the output queue
// the first width+1 requests of a frame and filler requests inside a frame give no result
// reset clears counters, window and queue; the line memories are not cleared
// an output stall fills the two-entry output queue and then holds s_tready low
module bayer_bilinear_demosaic #(
	parameter int MAX_WIDTH  = 4096,
	parameter int PIXEL_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_tdata,  // raw_pixel
	input  logic                                  s_tuser,  // filler

	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((3*PIXEL_BITS+7)/8)*8-1:0]     m_tdata,  // red, green, blue
	output logic                                  m_tlast,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  bbd_pkg::cfg_addr_t                    cfg_addr,
	input  logic [bbd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int PB          = PIXEL_BITS;
	localparam int AW          = $clog2(MAX_WIDTH);
	localparam int CW          = AW + 1;
	localparam int WW          = $clog2(MAX_WIDTH + 1);
	localparam int RB          = bbd_pkg::ROW_BITS;
	localparam int OUT_W       = ((3*PIXEL_BITS+7)/8)*8;
	localparam int WIDTH_RESET = (bbd_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : bbd_pkg::IMAGE_WIDTH_RESET;

	// configuration
	logic [WW-1:0]                  width_q;
	logic [RB-1:0]                  height_q;
	logic [bbd_pkg::TILE_BITS-1:0]  tile_q;
	logic                           cfg_hit;

	// counters and stage 1
	logic [AW-1:0]        col_q;
	logic [RB-1:0]        row_q;
	logic [AW-1:0]        col_d;
	logic [RB-1:0]        row_d;
	logic                 accept;
	logic                 raw;
	logic                 ignore;
	logic                 skip;
	logic                 last;
	logic [CW-1:0]        col_inc;
	bbd_pkg::stage_ctl_t  ctl_d;
	bbd_pkg::stage_ctl_t  ctl_s1;
	logic                 valid_s1;
	logic [PB-1:0]        pix_s1;
	logic [AW-1:0]        col_s1;

	// line memories
	logic [PB-1:0] line_prev_mem  [MAX_WIDTH];
	logic [PB-1:0] line_older_mem [MAX_WIDTH];
	logic [PB-1:0] prev_s1;
	logic [PB-1:0] older_s1;
	logic          wr_en;

	// window and interpolation
	logic [PB-1:0] win_q [3][3];
	logic [PB-1:0] win_d [3][3];
	logic [PB+1:0] diag_sum;
	logic [PB+1:0] cross_sum;
	logic [PB:0]   horiz_sum;
	logic [PB:0]   vert_sum;
	logic [PB-1:0] diag;
	logic [PB-1:0] cross_avg;
	logic [PB-1:0] horiz;
	logic [PB-1:0] vert;
	logic [PB-1:0] red;
	logic [PB-1:0] green;
	logic [PB-1:0] blue;

	// output queue
	logic [3*PB:0] queue_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_addr == bbd_pkg::REG_IMAGE_WIDTH ||
		cfg_addr == bbd_pkg::REG_IMAGE_HEIGHT || cfg_addr == bbd_pkg::REG_TILE_PATTERN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_RESET);
			height_q <= RB'(bbd_pkg::IMAGE_HEIGHT_RESET);
			tile_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr)
				bbd_pkg::REG_IMAGE_WIDTH: begin
					if (cfg_data < bbd_pkg::CFG_DATA_BITS'(bbd_pkg::MIN_DIM))
						width_q <= WW'(bbd_pkg::MIN_DIM);
					else if (32'(cfg_data) > MAX_WIDTH)
						width_q <= WW'(MAX_WIDTH);
					else
						width_q <= WW'(cfg_data);
				end
				bbd_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg_data < bbd_pkg::CFG_DATA_BITS'(bbd_pkg::MIN_DIM))
						height_q <= RB'(bbd_pkg::MIN_DIM);
					else if (32'(cfg_data) > bbd_pkg::MAX_HEIGHT)
						height_q <= RB'(bbd_pkg::MAX_HEIGHT);
					else
						height_q <= RB'(cfg_data);
				end
				bbd_pkg::REG_TILE_PATTERN: begin
					tile_q <= cfg_data[bbd_pkg::TILE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// request decode at the counters
	assign accept  = s_tvalid && s_tready;
	assign raw     = row_q < height_q;
	assign ignore  = raw && s_tuser;
	assign skip    = (row_q == '0) || (row_q == RB'(1) && col_q == '0);
	assign last    = (col_q == '0) && (row_q == height_q + RB'(1));
	assign col_inc = {1'b0, col_q} + CW'(1);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (!ignore) begin
			if (last && !skip) begin
				col_d = '0;
				row_d = '0;
			end else if (col_inc >= CW'(width_q)) begin
				col_d = '0;
				row_d = row_q + RB'(1);
			end else begin
				col_d = col_inc[AW-1:0];
			end
		end
		ctl_d.shift    = raw && !s_tuser;
		ctl_d.emit     = !skip;
		ctl_d.interior = raw && (col_q >= AW'(2)) && (row_q >= RB'(2));
		ctl_d.red_row  = (~row_q[0]) == tile_q[0];
		ctl_d.red_col  = (~col_q[0]) == tile_q[1];
		ctl_d.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && !ignore;
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
			pix_s1 <= s_tdata[PB-1:0];
			col_s1 <= col_q;
		end
	end

	// read at stage 0, write back in the following cycle; the same column comes back
	// no sooner than width requests later, so read and write never meet
	assign wr_en = valid_s1 && ctl_s1.shift;

	always_ff @(posedge clk) begin
		if (accept)
			prev_s1 <= line_prev_mem[col_q];
		if (wr_en)
			line_prev_mem[col_s1] <= pix_s1;
	end

	always_ff @(posedge clk) begin
		if (accept)
			older_s1 <= line_older_mem[col_q];
		if (wr_en)
			line_older_mem[col_s1] <= prev_s1;
	end

	always_comb begin
		win_d = win_q;
		if (wr_en) begin
			for (int i = 0; i < 3; i++) begin
				win_d[i][0] = win_q[i][1];
				win_d[i][1] = win_q[i][2];
			end
			win_d[0][2] = older_s1;
			win_d[1][2] = prev_s1;
			win_d[2][2] = pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win_q[i][j] <= '0;
		end else begin
			win_q <= win_d;
		end
	end

	always_comb begin
		diag_sum  = {2'b00, win_d[0][0]} + {2'b00, win_d[0][2]} + {2'b00, win_d[2][0]} +
			{2'b00, win_d[2][2]} + (PB+2)'(2);
		cross_sum = {2'b00, win_d[0][1]} + {2'b00, win_d[2][1]} + {2'b00, win_d[1][0]} +
			{2'b00, win_d[1][2]} + (PB+2)'(2);
		horiz_sum = {1'b0, win_d[1][0]} + {1'b0, win_d[1][2]} + (PB+1)'(1);
		vert_sum  = {1'b0, win_d[0][1]} + {1'b0, win_d[2][1]} + (PB+1)'(1);
		diag      = diag_sum[PB+1:2];
		cross_avg = cross_sum[PB+1:2];
		horiz     = horiz_sum[PB:1];
		vert      = vert_sum[PB:1];
		red   = '0;
		green = '0;
		blue  = '0;
		if (ctl_s1.interior) begin
			if (ctl_s1.red_row && ctl_s1.red_col) begin
				red   = win_d[1][1];
				green = cross_avg;
				blue  = diag;
			end else if (!ctl_s1.red_row && !ctl_s1.red_col) begin
				red   = diag;
				green = cross_avg;
				blue  = win_d[1][1];
			end else if (ctl_s1.red_row) begin
				red   = horiz;
				green = win_d[1][1];
				blue  = vert;
			end else begin
				red   = vert;
				green = win_d[1][1];
				blue  = horiz;
			end
		end
	end

	// two-entry output queue; a request is taken only if its result will fit
	assign push     = valid_s1 && ctl_s1.emit;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (3'(count_q) + 3'(push)) <= (3'd1 + 3'(pop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= {ctl_s1.last, blue, green, red};
	end

	assign m_tvalid = count_q != '0;
	assign m_tdata  = OUT_W'(queue_q[rd_ptr_q][3*PB-1:0]);
	assign m_tlast  = queue_q[rd_ptr_q][3*PB];

endmodule

### rtl/bbd_checker.sv
// port checker for the demosaic, bound to the top level
`include "bayer_bilinear_demosaic_defines.svh"

module bbd_checker #(
	parameter int PIXEL_BITS = 8
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((3*PIXEL_BITS+7)/8)*8-1:0]     m_tdata,  // red, green, blue
	input logic                                  m_tlast,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready
);

	`BBD_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`BBD_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
	`BBD_ASSERT_NOW(a_frame_end_black, m_tvalid && m_tlast, m_tdata == '0, "frame end pixel is not black")
	`BBD_ASSERT_NOW(a_cfg_always_taken, cfg_valid, cfg_ready, "configuration write not taken")

endmodule

bind bayer_bilinear_demosaic bbd_checker #(.PIXEL_BITS(PIXEL_BITS)) u_bbd_checker (.*);

### tb/bayer_bilinear_demosaic_checker.sv
`timescale 1ns / 100ps
// checker for the bilinear bayer demosaic: predicts rgb pixels and compares the output stream
module bayer_bilinear_demosaic_checker
	import bbd_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_tdata,  // raw_pixel
	input  logic                                  s_tuser,  // filler
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [((3*PIXEL_BITS+7)/8)*8-1:0]     m_tdata,  // red, green, blue
	input  logic                                  m_tlast,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  cfg_addr_t                             cfg_addr,
	input  logic [CFG_DATA_BITS-1:0]              cfg_data,
	output int                                    mismatches,
	output int                                    pending
);

	typedef enum logic [TILE_BITS-1:0] {
		TILE_RGGB = 2'd0,
		TILE_GBRG = 2'd1,
		TILE_GRBG = 2'd2,
		TILE_BGGR = 2'd3
	} tile_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] red;
		logic [PIXEL_BITS-1:0] green;
		logic [PIXEL_BITS-1:0] blue;
		logic                  frame_end;
	} rgb_pixel_t;

	rgb_pixel_t expected_pixels[$];

	logic [CFG_DATA_BITS-1:0] width_reg;
	logic [CFG_DATA_BITS-1:0] height_reg;
	logic [TILE_BITS-1:0]     tile_reg;
	logic [PIXEL_BITS-1:0]    line_mem [2*MAX_WIDTH];
	logic [PIXEL_BITS-1:0]    win [3][3];
	int                       col_pos;
	int                       row_pos;

	function automatic int clamp_dim(input logic [CFG_DATA_BITS-1:0] v, input int hi);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic logic [PIXEL_BITS-1:0] mean2(input logic [PIXEL_BITS-1:0] a, b);
		logic [PIXEL_BITS:0] s;
		s = {1'b0, a} + {1'b0, b} + (PIXEL_BITS+1)'(1);
		return s[PIXEL_BITS:1];
	endfunction

	function automatic logic [PIXEL_BITS-1:0] mean4(input logic [PIXEL_BITS-1:0] a, b, c, d);
		logic [PIXEL_BITS+1:0] s;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d} + (PIXEL_BITS+2)'(2);
		return s[PIXEL_BITS+1:2];
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 100) begin
			$display("%0t ns: %s", $time, msg);
		end
		mismatches++;
	endtask

	function automatic void apply_register(input cfg_addr_t addr,
			input logic [CFG_DATA_BITS-1:0] data);
		case (addr)
			REG_IMAGE_WIDTH: width_reg = data;
			REG_IMAGE_HEIGHT: height_reg = data;
			REG_TILE_PATTERN: tile_reg = data[TILE_BITS-1:0];
			default: return;
		endcase
		col_pos = 0;
		row_pos = 0;
	endfunction

	function automatic void demosaic_step(input logic [PIXEL_BITS-1:0] pix, input logic fill);
		int w, h, col, row, oy, ox;
		bit in_frame, last, red_row, red_col;
		rgb_pixel_t px;
		logic [PIXEL_BITS-1:0] c, cross_g, diag, horiz, vert;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		col = (col_pos >= w) ? w - 1 : col_pos;
		row = row_pos;
		in_frame = row < h;
		if (in_frame) begin
			// filler inside the frame is dropped without a trace
			if (fill) return;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = line_mem[MAX_WIDTH + col];
			win[1][2] = line_mem[col];
			win[2][2] = pix;
			line_mem[MAX_WIDTH + col] = line_mem[col];
			line_mem[col] = pix;
		end
		// window not yet primed at the start of a frame
		if (row == 0 || (row == 1 && col == 0)) begin
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end
			col_pos = col;
			row_pos = row;
			return;
		end
		if (col >= 1) begin
			oy = row - 1;
			ox = col - 1;
		end else begin
			oy = row - 2;
			ox = w - 1;
		end
		px = '0;
		if (in_frame && oy >= 1 && oy + 2 <= h && ox >= 1 && ox + 2 <= w) begin
			red_row = (tile_reg == TILE_GBRG || tile_reg == TILE_BGGR);
			red_col = (tile_reg == TILE_GRBG || tile_reg == TILE_BGGR);
			c = win[1][1];
			cross_g = mean4(win[0][1], win[2][1], win[1][0], win[1][2]);
			diag = mean4(win[0][0], win[0][2], win[2][0], win[2][2]);
			horiz = mean2(win[1][0], win[1][2]);
			vert = mean2(win[0][1], win[2][1]);
			if (oy[0] == red_row && ox[0] == red_col) begin
				px.red = c;
				px.green = cross_g;
				px.blue = diag;
			end else if (oy[0] != red_row && ox[0] != red_col) begin
				px.red = diag;
				px.green = cross_g;
				px.blue = c;
			end else if (oy[0] == red_row) begin
				px.red = horiz;
				px.green = c;
				px.blue = vert;
			end else begin
				px.red = vert;
				px.green = c;
				px.blue = horiz;
			end
		end
		last = (oy == h - 1) && (ox == w - 1);
		px.frame_end = last;
		expected_pixels.push_back(px);
		if (last) begin
			col = 0;
			row = 0;
		end else begin
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end
		end
		col_pos = col;
		row_pos = row;
	endfunction

	task automatic check_pixel();
		rgb_pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("pixel %h last %b with none expected", m_tdata, m_tlast));
			return;
		end
		want = expected_pixels.pop_front();
		if (m_tdata[PIXEL_BITS-1:0] !== want.red)
			report_mismatch($sformatf("red %h, expected %h",
				m_tdata[PIXEL_BITS-1:0], want.red));
		if (m_tdata[2*PIXEL_BITS-1:PIXEL_BITS] !== want.green)
			report_mismatch($sformatf("green %h, expected %h",
				m_tdata[2*PIXEL_BITS-1:PIXEL_BITS], want.green));
		if (m_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS] !== want.blue)
			report_mismatch($sformatf("blue %h, expected %h",
				m_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS], want.blue));
		if (m_tlast !== want.frame_end)
			report_mismatch($sformatf("frame end %b, expected %b", m_tlast, want.frame_end));
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_DATA_BITS'(IMAGE_WIDTH_RESET);
			height_reg = CFG_DATA_BITS'(IMAGE_HEIGHT_RESET);
			tile_reg = TILE_RGGB;
			for (int i = 0; i < 2*MAX_WIDTH; i++) line_mem[i] = '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win[i][j] = '0;
			col_pos = 0;
			row_pos = 0;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) apply_register(cfg_addr, cfg_data);
			if (s_tvalid && s_tready) demosaic_step(s_tdata[PIXEL_BITS-1:0], s_tuser);
			if (m_tvalid && m_tready) check_pixel();
		end
		pending = expected_pixels.size();
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// testbench top for the bilinear bayer demosaic: stimulus, idling and verdict
module tb;
	import bbd_pkg::*;

	localparam int MAX_WIDTH     = 4096;
	localparam int PIXEL_BITS    = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 900;
	localparam int WIDE_CUT      = 40;
	localparam int TALL_CUT      = 60;

	// index past the register list, written to check that it is ignored
	localparam cfg_addr_t REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;

	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [PIXEL_BITS-1:0]     s_tdata = '0;   // raw_pixel
	logic                      s_tuser = 1'b0; // filler
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [3*PIXEL_BITS-1:0]   m_tdata;        // red, green, blue
	logic                      m_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	cfg_addr_t                 cfg_addr = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int mismatches;
	int pending;
	int src_idle_pct = 20;
	int snk_idle_pct = 87;
	int items_sent = 0;
	int cur_w = IMAGE_WIDTH_RESET;
	int cur_h = IMAGE_HEIGHT_RESET;

	bayer_bilinear_demosaic #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	bayer_bilinear_demosaic_checker #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic logic [PIXEL_BITS-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIXEL_BITS'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [PIXEL_BITS-1:0] pix, input logic fill);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= fill;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop the source and let every pending pixel come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need one assignment per cycle
	task automatic write_reg(input cfg_addr_t addr, input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input int w_data, input int h_data, input int tile_data);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w_data));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h_data));
		write_reg(REG_TILE_PATTERN, CFG_DATA_BITS'(tile_data));
		cfg_valid <= 1'b0;
		cur_w = (w_data < MIN_DIM) ? MIN_DIM : (w_data > MAX_WIDTH) ? MAX_WIDTH : w_data;
		cur_h = (h_data < MIN_DIM) ? MIN_DIM : (h_data > MAX_HEIGHT) ? MAX_HEIGHT : h_data;
	endtask

	// mid-frame pause until the output is empty, sometimes with a stray register write
	task automatic hold_off(input bit stray_write);
		wait_idle();
		if (stray_write) begin
			write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom_range(8191)));
			cfg_valid <= 1'b0;
		end
	endtask

	task automatic send_frame(input int cut);
		int n;
		n = cur_w * cur_h;
		for (int i = 0; i < n; i++) begin
			if (i == cut) return;
			if ($urandom_range(99) < 4) send_item(rand_pixel(), 1'b1);
			if ($urandom_range(499) == 0) hold_off(1'($urandom_range(1)));
			send_item(rand_pixel(), 1'b0);
			items_sent++;
		end
		for (int i = 0; i <= cur_w; i++) begin
			if ($urandom_range(99) < 10) send_item(rand_pixel(), 1'b0);
			else send_item(rand_pixel(), 1'b1);
			items_sent++;
		end
	endtask

	task automatic run_random(input int quota);
		int goal, frames;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			if ($urandom_range(9) < 8)
				configure($urandom_range(2, 10), $urandom_range(2, 6), $urandom_range(8191));
			else
				configure($urandom_range(0, 40), $urandom_range(0, 5), $urandom_range(8191));
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				if (f == frames - 1 && $urandom_range(99) < 15)
					send_frame($urandom_range(1, cur_w * cur_h - 1));
				else
					send_frame(-1);
			end
		end
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL bayer_bilinear_demosaic");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4x4 frame: all four color sites in the interior, extreme samples
		configure(4, 4, $urandom_range(8191));
		for (int i = 0; i < 16; i++) begin
			if (i == 6) send_item(8'h3c, 1'b1);
			if (i == 9) hold_off(1'b1);
			send_item((i % 2) ? 8'hff : 8'h00, 1'b0);
		end
		send_item(8'h5a, 1'b0);
		for (int i = 0; i < 4; i++) send_item(8'hff, 1'b1);

		run_random(RANDOM_ITEMS / 3);

		src_idle_pct = 87;
		snk_idle_pct = 20;
		run_random(RANDOM_ITEMS / 3);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_random(RANDOM_ITEMS / 3);

		// start of the widest and tallest frames, via out-of-range and exact register values
		configure(8191, 3, $urandom_range(8191));
		send_frame(WIDE_CUT);
		configure(3, MAX_HEIGHT, $urandom_range(8191));
		send_frame(TALL_CUT);

		wait_idle();
		if (mismatches == 0)
			$display("PASS bayer_bilinear_demosaic");
		else
			$display("FAIL bayer_bilinear_demosaic");
		$finish;
	end

endmodule
